/* hdl/value_priority_bounded_delay_buffer_unit_macros.svh */
// assertion macros used by the buffer top level
`ifndef VALUE_PRIORITY_BOUNDED_DELAY_BUFFER_UNIT_MACROS_SVH
`define VALUE_PRIORITY_BOUNDED_DELAY_BUFFER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, clocked on aclk, off during reset
`define VPBDB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("vpbdb assertion failed");
// next-cycle implication
`define VPBDB_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("vpbdb assertion failed");
`else
`define VPBDB_ASSERT_IMP(label, ante, cons)
`define VPBDB_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* hdl/vpbdb_pkg.sv */
// types and constants of the value priority bounded delay buffer
`default_nettype none
package vpbdb_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FILL_W   = $clog2(CAPACITY + 1);
    localparam int CFG_W    = 5;
    localparam int COUNT_W  = 8;
    localparam int SLACK_W  = 8;
    localparam int VALUE_W  = 16;
    localparam int TOTAL_W  = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);
    localparam logic signed [SLACK_W-1:0] SLACK_ZERO = '0;

    localparam logic MODE_ARRIVAL = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

    typedef struct packed {
        logic                      mode;
        logic [COUNT_W-1:0]        packet_count;
        logic signed [SLACK_W-1:0] packet_slack;
        logic [VALUE_W-1:0]        packet_value;
    } in_t;

    typedef struct packed {
        logic               sent_valid;
        logic [VALUE_W-1:0] sent_value;
        logic [TOTAL_W-1:0] arrived_total;
        logic [TOTAL_W-1:0] dropped_total;
        logic [TOTAL_W-1:0] sent_total;
        logic [TOTAL_W-1:0] value_sum;
    } out_t;

    // broadcast command to every cell of the row
    typedef struct packed {
        logic                      load;
        logic                      shift;
        logic                      decr;
        logic [IDX_W-1:0]          sel_idx;
        logic signed [SLACK_W-1:0] slack;
        logic [VALUE_W-1:0]        value;
    } cell_cmd_t;

    // search token walking down the row, one cell per cycle
    typedef struct packed {
        logic               active;
        logic               find_max;
        logic               found;
        logic [VALUE_W-1:0] best_val;
        logic [IDX_W-1:0]   best_idx;
    } token_t;

endpackage
`default_nettype wire

/* hdl/vpbdb_cell.sv */
// one buffer slot: slack and value storage plus one stage of the search token
`default_nettype none
module vpbdb_cell (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire [vpbdb_pkg::IDX_W-1:0]        cell_idx,
    input  wire                               occupied,
    input  vpbdb_pkg::cell_cmd_t              cmd,
    input  wire signed [vpbdb_pkg::SLACK_W-1:0] nbr_slack,
    input  wire [vpbdb_pkg::VALUE_W-1:0]      nbr_value,
    input  vpbdb_pkg::token_t                 token_in,
    output logic signed [vpbdb_pkg::SLACK_W-1:0] slack_out,
    output logic [vpbdb_pkg::VALUE_W-1:0]     value_out,
    output logic                              expired,
    output vpbdb_pkg::token_t                 token_out
);
    import vpbdb_pkg::*;

    logic signed [SLACK_W-1:0] slack_reg, slack_next;
    logic [VALUE_W-1:0]        value_reg, value_next;
    token_t                    tok_reg, tok_next;
    logic                      load_here;
    logic                      shift_here;

    assign load_here  = cmd.load && (cell_idx == cmd.sel_idx);
    // removal closes the gap: every slot at or above the removed one takes its upper neighbor
    assign shift_here = cmd.shift && (cell_idx >= cmd.sel_idx);

    always_comb begin
        slack_next = slack_reg;
        value_next = value_reg;
        if (load_here) begin
            slack_next = cmd.slack;
            value_next = cmd.value;
        end else if (shift_here) begin
            slack_next = nbr_slack;
            value_next = nbr_value;
        end else if (cmd.decr) begin
            slack_next = slack_reg - SLACK_W'(1);
        end
    end

    always_comb begin
        tok_next = token_in;
        if (token_in.active && occupied) begin
            if (token_in.find_max) begin
                // strict compare keeps the first maximum
                if (value_reg > token_in.best_val) begin
                    tok_next.best_val = value_reg;
                    tok_next.best_idx = cell_idx;
                end
            end else if ((value_reg < cmd.value) && (value_reg <= token_in.best_val)) begin
                // non-strict compare keeps the last minimum below the key
                tok_next.found    = 1'b1;
                tok_next.best_val = value_reg;
                tok_next.best_idx = cell_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        slack_reg <= slack_next;
        value_reg <= value_next;
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign slack_out = slack_reg;
    assign value_out = value_reg;
    assign expired   = occupied && (slack_reg <= SLACK_ZERO);
    assign token_out = tok_reg;

endmodule
`default_nettype wire

/* hdl/vpbdb_row.sv */
// row of buffer cells with gap-closing chain and first-expired lookup
`default_nettype none
module vpbdb_row (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire [vpbdb_pkg::FILL_W-1:0]   fill,
    input  vpbdb_pkg::cell_cmd_t          cmd,
    input  vpbdb_pkg::token_t             head_token,
    output vpbdb_pkg::token_t             tail_token,
    output logic [vpbdb_pkg::VALUE_W-1:0] head_value,
    output logic                          any_expired,
    output logic [vpbdb_pkg::IDX_W-1:0]   first_expired
);
    import vpbdb_pkg::*;

    logic signed [SLACK_W-1:0] slack_a [CAPACITY];
    logic [VALUE_W-1:0]        value_a [CAPACITY];
    logic [CAPACITY-1:0]       expired_a;
    logic [CAPACITY-1:0]       occ_a;
    token_t                    tok_a [CAPACITY+1];

    assign tok_a[0] = head_token;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [SLACK_W-1:0] nbr_slack;
        logic [VALUE_W-1:0]        nbr_value;

        if (g == CAPACITY - 1) begin : g_last
            assign nbr_slack = slack_a[g];
            assign nbr_value = value_a[g];
        end else begin : g_mid
            assign nbr_slack = slack_a[g+1];
            assign nbr_value = value_a[g+1];
        end

        assign occ_a[g] = (FILL_W'(g) < fill);

        vpbdb_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_idx  (IDX_W'(g)),
            .occupied  (occ_a[g]),
            .cmd       (cmd),
            .nbr_slack (nbr_slack),
            .nbr_value (nbr_value),
            .token_in  (tok_a[g]),
            .slack_out (slack_a[g]),
            .value_out (value_a[g]),
            .expired   (expired_a[g]),
            .token_out (tok_a[g+1])
        );
    end

    // priority encode, lowest index wins
    always_comb begin
        any_expired   = 1'b0;
        first_expired = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (expired_a[i]) begin
                any_expired   = 1'b1;
                first_expired = IDX_W'(i);
            end
        end
    end

    assign tail_token = tok_a[CAPACITY];
    assign head_value = value_a[0];

endmodule
`default_nettype wire

/* hdl/value_priority_bounded_delay_buffer_unit.sv */
// value priority bounded delay buffer, top level
// Takes requests on s_valid/s_ready/s_data and returns one result per request on
// m_valid/m_ready/m_data. An arrival request (mode 0) stores up to the configured
// number of copies of a packet; a tick request (mode 1) removes expired packets,
// ages the rest and sends the first packet of highest value.
// cfg_wr_en/cfg_wr_data set the number of slots in use; write only while idle.
// Requests are handled one at a time by a sequencer driving a row of CAPACITY cells.
// Arrival: copies are stored in free slots one after another; once full, each copy
// runs a replacement search walking the row, and the first copy that finds
// nothing ends the request.
// Tick: expired packets are removed one at a time; the rest are aged when the
// buffer holds packets, newly expired ones are removed, and the maximum search
// runs when packets survive the aging.
// The search token walks the row one cell per cycle.
// A finished result waits in the output register while the next request is
// taken; the sequencer stalls before writing a second result if m_ready is low.
// Reset empties the buffer, clears all totals and sets the capacity to 16.
`default_nettype none
`include "value_priority_bounded_delay_buffer_unit_macros.svh"
module value_priority_bounded_delay_buffer_unit (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         cfg_wr_en,
    input  wire [vpbdb_pkg::CFG_W-1:0]  cfg_wr_data,
    input  wire                         s_valid,
    output logic                        s_ready,
    input  vpbdb_pkg::in_t              s_data,
    output logic                        m_valid,
    input  wire                         m_ready,
    output vpbdb_pkg::out_t             m_data
);
    import vpbdb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COPY,
        ST_REPL,
        ST_PURGE1,
        ST_PURGE2,
        ST_MAX,
        ST_RESULT
    } state_t;

    state_t                    state_reg, state_next;
    logic [CFG_W-1:0]          cfg_reg, cfg_next;
    logic [FILL_W-1:0]         fill_reg, fill_next;
    logic [COUNT_W-1:0]        copies_reg, copies_next;
    logic [TOTAL_W-1:0]        arrived_reg, arrived_next;
    logic [TOTAL_W-1:0]        dropped_reg, dropped_next;
    logic [TOTAL_W-1:0]        sent_reg, sent_next;
    logic [TOTAL_W-1:0]        sum_reg, sum_next;
    logic signed [SLACK_W-1:0] key_slack_reg, key_slack_next;
    logic [VALUE_W-1:0]        key_value_reg, key_value_next;
    logic                      res_valid_reg, res_valid_next;
    logic [VALUE_W-1:0]        res_value_reg, res_value_next;
    logic                      m_valid_reg, m_valid_next;
    out_t                      m_data_reg, m_data_next;

    logic [FILL_W-1:0]         cap_eff;
    cell_cmd_t                 cmd;
    token_t                    head_tok;
    token_t                    tail_tok;
    logic [VALUE_W-1:0]        head_value;
    logic                      any_expired;
    logic [IDX_W-1:0]          first_expired;
    logic                      send_fire;
    logic                      repl_fire;

    vpbdb_row u_row (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fill          (fill_reg),
        .cmd           (cmd),
        .head_token    (head_tok),
        .tail_token    (tail_tok),
        .head_value    (head_value),
        .any_expired   (any_expired),
        .first_expired (first_expired)
    );

    assign send_fire = (state_reg == ST_MAX) && tail_tok.active;
    assign repl_fire = (state_reg == ST_REPL) && tail_tok.active && tail_tok.found;

    always_comb begin
        if (32'(cfg_reg) > 32'(CAPACITY)) begin
            cap_eff = FILL_W'(CAPACITY);
        end else begin
            cap_eff = FILL_W'(cfg_reg);
        end
    end

    always_comb begin
        state_next     = state_reg;
        cfg_next       = cfg_wr_en ? cfg_wr_data : cfg_reg;
        fill_next      = fill_reg;
        copies_next    = copies_reg;
        arrived_next   = arrived_reg;
        dropped_next   = dropped_reg;
        sent_next      = sent_reg;
        sum_next       = sum_reg;
        key_slack_next = key_slack_reg;
        key_value_next = key_value_reg;
        res_valid_next = res_valid_reg;
        res_value_next = res_value_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;

        cmd            = '0;
        cmd.slack      = key_slack_reg;
        cmd.value      = key_value_reg;
        head_tok       = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    res_valid_next = 1'b0;
                    res_value_next = '0;
                    key_slack_next = s_data.packet_slack;
                    key_value_next = s_data.packet_value;
                    if (s_data.mode == MODE_ARRIVAL) begin
                        arrived_next = arrived_reg + TOTAL_W'(s_data.packet_count);
                        if (32'(s_data.packet_count) > 32'(cap_eff)) begin
                            dropped_next = dropped_reg + TOTAL_W'(s_data.packet_count)
                                           - TOTAL_W'(cap_eff);
                            copies_next  = COUNT_W'(cap_eff);
                        end else begin
                            copies_next  = s_data.packet_count;
                        end
                        state_next = ST_COPY;
                    end else begin
                        state_next = ST_PURGE1;
                    end
                end
            end
            ST_COPY: begin
                if (copies_reg == '0) begin
                    state_next = ST_RESULT;
                end else if (fill_reg < cap_eff) begin
                    cmd.load    = 1'b1;
                    cmd.sel_idx = IDX_W'(fill_reg);
                    fill_next   = fill_reg + FILL_W'(1);
                    copies_next = copies_reg - COUNT_W'(1);
                end else if (fill_reg == '0) begin
                    // zero capacity: nothing to replace
                    dropped_next = dropped_reg + TOTAL_W'(copies_reg);
                    copies_next  = '0;
                end else begin
                    dropped_next      = dropped_reg + TOTAL_W'(1);
                    head_tok.active   = 1'b1;
                    head_tok.find_max = 1'b0;
                    head_tok.best_val = head_value;
                    state_next        = ST_REPL;
                end
            end
            ST_REPL: begin
                if (tail_tok.active) begin
                    if (repl_fire) begin
                        cmd.load    = 1'b1;
                        cmd.sel_idx = tail_tok.best_idx;
                        copies_next = copies_reg - COUNT_W'(1);
                    end else begin
                        // contents unchanged, so every later copy misses too
                        dropped_next = dropped_reg + TOTAL_W'(copies_reg - COUNT_W'(1));
                        copies_next  = '0;
                    end
                    state_next = ST_COPY;
                end
            end
            ST_PURGE1: begin
                if (any_expired) begin
                    cmd.shift    = 1'b1;
                    cmd.sel_idx  = first_expired;
                    fill_next    = fill_reg - FILL_W'(1);
                    dropped_next = dropped_reg + TOTAL_W'(1);
                end else if (fill_reg == '0) begin
                    state_next = ST_RESULT;
                end else begin
                    cmd.decr   = 1'b1;
                    state_next = ST_PURGE2;
                end
            end
            ST_PURGE2: begin
                if (any_expired) begin
                    cmd.shift    = 1'b1;
                    cmd.sel_idx  = first_expired;
                    fill_next    = fill_reg - FILL_W'(1);
                    dropped_next = dropped_reg + TOTAL_W'(1);
                end else if (fill_reg == '0) begin
                    state_next = ST_RESULT;
                end else begin
                    head_tok.active   = 1'b1;
                    head_tok.find_max = 1'b1;
                    head_tok.best_val = head_value;
                    state_next        = ST_MAX;
                end
            end
            ST_MAX: begin
                if (send_fire) begin
                    cmd.shift      = 1'b1;
                    cmd.sel_idx    = tail_tok.best_idx;
                    fill_next      = fill_reg - FILL_W'(1);
                    sent_next      = sent_reg + TOTAL_W'(1);
                    sum_next       = sum_reg + TOTAL_W'(tail_tok.best_val);
                    res_valid_next = 1'b1;
                    res_value_next = tail_tok.best_val;
                    state_next     = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.sent_valid    = res_valid_reg;
                    m_data_next.sent_value    = res_value_reg;
                    m_data_next.arrived_total = arrived_reg;
                    m_data_next.dropped_total = dropped_reg;
                    m_data_next.sent_total    = sent_reg;
                    m_data_next.value_sum     = sum_reg;
                    state_next                = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cfg_reg     <= CFG_RESET;
            fill_reg    <= '0;
            copies_reg  <= '0;
            arrived_reg <= '0;
            dropped_reg <= '0;
            sent_reg    <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cfg_reg       <= cfg_next;
            fill_reg      <= fill_next;
            copies_reg    <= copies_next;
            arrived_reg   <= arrived_next;
            dropped_reg   <= dropped_next;
            sent_reg      <= sent_next;
            sum_reg       <= sum_next;
            m_valid_reg   <= m_valid_next;
            key_slack_reg <= key_slack_next;
            key_value_reg <= key_value_next;
            res_valid_reg <= res_valid_next;
            res_value_reg <= res_value_next;
            m_data_reg    <= m_data_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `VPBDB_ASSERT_IMP(a_fill_bound, 1'b1, 32'(fill_reg) <= 32'(CAPACITY))
    `VPBDB_ASSERT_NXT(a_busy_after_request, s_valid && s_ready, !s_ready)
    `VPBDB_ASSERT_NXT(a_send_shrinks, send_fire, fill_reg == $past(fill_reg) - FILL_W'(1))
    `VPBDB_ASSERT_IMP(a_no_send_zero, m_valid && !m_data.sent_valid, m_data.sent_value == '0)
    `VPBDB_ASSERT_IMP(a_repl_in_range, repl_fire, 32'(tail_tok.best_idx) < 32'(fill_reg))

endmodule
`default_nettype wire
